/* rtl/angle_sum_incircle_test_assert.svh */
// Assertion macros for the port checker of the in-circle test block.
`ifndef ANGLE_SUM_INCIRCLE_TEST_ASSERT_SVH
`define ANGLE_SUM_INCIRCLE_TEST_ASSERT_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define AICS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define AICS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/aics_pkg.sv */
// Package of the in-circle test block: widths, constants, tables and payload types.
package aics_pkg;

    localparam int COORD_BITS      = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int TOL_BITS        = 13;
    localparam int SUM_BITS        = 16;
    localparam int DIFF_BITS       = COORD_BITS + 1;
    localparam int CORDIC_STEPS    = 30;
    localparam int CW              = 64;
    localparam int ZW              = 34;
    localparam int ANG_W           = 32;
    localparam int NORM_MSB        = 59;
    localparam int LANE_LAT        = CORDIC_STEPS + 1;
    localparam int RND_SH          = 30 - ANGLE_FRAC_BITS;

    localparam longint PI_Q30_L = 64'sd3373259426;
    localparam logic signed [ZW-1:0] PI_Q30 = ZW'(PI_Q30_L);
    localparam logic [SUM_BITS-1:0] PI_OUT =
        SUM_BITS'((PI_Q30_L + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH);

    // atan(2^-i) in Q30.
    localparam logic signed [ZW-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
        34'sd4194283, 34'sd2097149, 34'sd1048576, 34'sd524288, 34'sd262144,
        34'sd131072, 34'sd65536, 34'sd32768, 34'sd16384, 34'sd8192, 34'sd4096,
        34'sd2048, 34'sd1024, 34'sd512, 34'sd256, 34'sd128, 34'sd64, 34'sd32,
        34'sd16, 34'sd8, 34'sd4, 34'sd2};

    // Position codes.
    localparam logic [1:0] POS_ON      = 2'd0;
    localparam logic [1:0] POS_INSIDE  = 2'd1;
    localparam logic [1:0] POS_OUTSIDE = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_a_x;
        logic signed [COORD_BITS-1:0] point_a_y;
        logic signed [COORD_BITS-1:0] point_b_x;
        logic signed [COORD_BITS-1:0] point_b_y;
        logic signed [COORD_BITS-1:0] point_c_x;
        logic signed [COORD_BITS-1:0] point_c_y;
        logic signed [COORD_BITS-1:0] point_d_x;
        logic signed [COORD_BITS-1:0] point_d_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          position;
        logic [SUM_BITS-1:0] angle_sum;
        logic                degenerate;
    } out_item_t;

endpackage

/* rtl/aics_cordic.sv */
// Pipelined CORDIC vectoring lane: direction of one vector in Q30 radians.
module aics_cordic
    import aics_pkg::*;
(
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [DIFF_BITS-1:0] vec_x,
    input  logic signed [DIFF_BITS-1:0] vec_y,
    output logic signed [ZW-1:0]        angle
);

    logic signed [CW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS+1];

    logic                        neg;
    logic signed [DIFF_BITS-1:0] px, py;
    logic [DIFF_BITS-1:0]        mag_x, mag_y, mag_m;
    logic [4:0]                  msb;
    logic [5:0]                  shift;
    logic signed [CW-1:0]        x_next, y_next;

    // Fold into the right half plane and normalize the leading bit to NORM_MSB.
    always_comb
    begin
        neg   = vec_x[DIFF_BITS-1];
        px    = neg ? -vec_x : vec_x;
        py    = neg ? -vec_y : vec_y;
        mag_x = px[DIFF_BITS-1] ? DIFF_BITS'(-px) : DIFF_BITS'(px);
        mag_y = py[DIFF_BITS-1] ? DIFF_BITS'(-py) : DIFF_BITS'(py);
        mag_m = (mag_x > mag_y) ? mag_x : mag_y;
        msb   = 5'd0;
        for (int k = 0; k < DIFF_BITS; k++)
        begin
            if (mag_m[k])
            begin
                msb = 5'(k);
            end
        end
        shift  = 6'(NORM_MSB - int'(msb));
        x_next = CW'(px) <<< shift;
        y_next = CW'(py) <<< shift;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x_next;
            y_reg[0] <= y_next;
            z_reg[0] <= neg ? PI_Q30 : '0;
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_Q30[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_Q30[i];
                end
            end
        end
    end

    assign angle = z_reg[CORDIC_STEPS];

endmodule

/* rtl/angle_sum_incircle_test.sv */
// A result passes the edge stage, the 30-step CORDIC lanes and the tail stages.
// Throughput: one item per cycle; four CORDIC lanes run side by side.
// The whole pipeline advances unless the output holds a result under stall.
// Reset (rst_n, asynchronous, active low) clears valid bits and sets tol_reg to 0.
// Payload registers are not reset.
module angle_sum_incircle_test
    import aics_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_data,
    input  logic                cfg_we,
    input  logic [TOL_BITS-1:0] cfg_data
);

    localparam int LAST = LANE_LAT + 5;

    logic                        adv;
    logic [TOL_BITS-1:0]         tol_reg;
    logic                        vld_reg [1:LAST];
    logic                        deg_reg [1:LAST];
    logic signed [DIFF_BITS-1:0] dif_reg [8];
    logic signed [ZW-1:0]        zl [4];
    logic signed [ZW:0]          ang_dif_reg [2];
    logic [ANG_W-1:0]            ang_reg [2];
    logic [SUM_BITS-1:0]         sum_reg;
    out_item_t                   out_reg;
    logic                        deg_next;
    logic [ANG_W-1:0]            fold_next [2];
    logic [ANG_W:0]              sum_full;
    logic signed [SUM_BITS+1:0]  pi_dif;
    logic [SUM_BITS+1:0]         pi_mag;
    out_item_t                   out_next;

    assign adv      = !(vld_reg[LAST] && out_stall);
    assign in_stall = !adv;

    // Tolerance register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_data;
        end
    end

    // Valid and degenerate flags travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[1] <= in_valid;
            for (int k = 2; k <= LAST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deg_reg[1] <= deg_next;
            for (int k = 2; k <= LAST; k++)
            begin
                deg_reg[k] <= deg_reg[k-1];
            end
        end
    end

    // Stage one: edge vectors from both vertices.
    always_comb
    begin
        logic signed [DIFF_BITS-1:0] d [8];
        d[0] = DIFF_BITS'(in_data.point_a_x) - DIFF_BITS'(in_data.point_b_x);
        d[1] = DIFF_BITS'(in_data.point_a_y) - DIFF_BITS'(in_data.point_b_y);
        d[2] = DIFF_BITS'(in_data.point_c_x) - DIFF_BITS'(in_data.point_b_x);
        d[3] = DIFF_BITS'(in_data.point_c_y) - DIFF_BITS'(in_data.point_b_y);
        d[4] = DIFF_BITS'(in_data.point_a_x) - DIFF_BITS'(in_data.point_d_x);
        d[5] = DIFF_BITS'(in_data.point_a_y) - DIFF_BITS'(in_data.point_d_y);
        d[6] = DIFF_BITS'(in_data.point_c_x) - DIFF_BITS'(in_data.point_d_x);
        d[7] = DIFF_BITS'(in_data.point_c_y) - DIFF_BITS'(in_data.point_d_y);
        deg_next = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (d[2*k] == '0 && d[2*k+1] == '0)
            begin
                deg_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dif_reg[0] <= DIFF_BITS'(in_data.point_a_x) - DIFF_BITS'(in_data.point_b_x);
            dif_reg[1] <= DIFF_BITS'(in_data.point_a_y) - DIFF_BITS'(in_data.point_b_y);
            dif_reg[2] <= DIFF_BITS'(in_data.point_c_x) - DIFF_BITS'(in_data.point_b_x);
            dif_reg[3] <= DIFF_BITS'(in_data.point_c_y) - DIFF_BITS'(in_data.point_b_y);
            dif_reg[4] <= DIFF_BITS'(in_data.point_a_x) - DIFF_BITS'(in_data.point_d_x);
            dif_reg[5] <= DIFF_BITS'(in_data.point_a_y) - DIFF_BITS'(in_data.point_d_y);
            dif_reg[6] <= DIFF_BITS'(in_data.point_c_x) - DIFF_BITS'(in_data.point_d_x);
            dif_reg[7] <= DIFF_BITS'(in_data.point_c_y) - DIFF_BITS'(in_data.point_d_y);
        end
    end

    // Four direction lanes.
    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        aics_cordic u_lane
        (
            .clk   (clk),
            .en    (adv),
            .vec_x (dif_reg[2*l]),
            .vec_y (dif_reg[2*l+1]),
            .angle (zl[l])
        );
    end

    // Fold the direction differences into [0, pi].
    always_comb
    begin
        logic [ZW:0] mag;
        for (int k = 0; k < 2; k++)
        begin
            mag = ang_dif_reg[k][ZW] ? (ZW+1)'(-ang_dif_reg[k]) : (ZW+1)'(ang_dif_reg[k]);
            if (mag > (ZW+1)'(PI_Q30))
            begin
                mag = ((ZW+1)'(PI_Q30) <<< 1) - mag;
            end
            fold_next[k] = mag[ANG_W-1:0];
        end
    end

    always_comb
    begin
        sum_full = (ANG_W+1)'(ang_reg[0]) + (ANG_W+1)'(ang_reg[1])
                   + (ANG_W+1)'(1 << (RND_SH - 1));
        pi_dif   = (SUM_BITS+2)'(sum_reg) - (SUM_BITS+2)'(PI_OUT);
        pi_mag   = pi_dif[SUM_BITS+1] ? (SUM_BITS+2)'(-pi_dif) : (SUM_BITS+2)'(pi_dif);
        out_next.degenerate = deg_reg[LAST-1];
        if (deg_reg[LAST-1])
        begin
            out_next.position  = POS_ON;
            out_next.angle_sum = '0;
        end
        else
        begin
            out_next.angle_sum = sum_reg;
            if (pi_mag <= (SUM_BITS+2)'(tol_reg))
            begin
                out_next.position = POS_ON;
            end
            else if (!pi_dif[SUM_BITS+1])
            begin
                out_next.position = POS_INSIDE;
            end
            else
            begin
                out_next.position = POS_OUTSIDE;
            end
        end
    end

    // Tail stages: difference, fold, sum and round, classify.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_dif_reg[0] <= (ZW+1)'(zl[0]) - (ZW+1)'(zl[1]);
            ang_dif_reg[1] <= (ZW+1)'(zl[2]) - (ZW+1)'(zl[3]);
            ang_reg[0]     <= fold_next[0];
            ang_reg[1]     <= fold_next[1];
            sum_reg        <= sum_full[RND_SH +: SUM_BITS];
            out_reg        <= out_next;
        end
    end

    assign out_valid = vld_reg[LAST];
    assign out_data  = out_reg;

endmodule

/* rtl/aics_checker.sv */
// Port checker for the in-circle test block, with its bind.
`include "angle_sum_incircle_test_assert.svh"

module aics_checker
    import aics_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input out_item_t out_data,
    input logic      out_valid,
    input logic      out_stall
);

    `AICS_ASSERT_NOW(a_deg_zero, out_valid && out_data.degenerate, out_data.position == POS_ON && out_data.angle_sum == '0, "degenerate result carries nonzero fields")
    `AICS_ASSERT_NOW(a_flow, !out_stall, !in_stall, "input stalled while output is free")
    `AICS_ASSERT_NOW(a_block, out_valid && out_stall, in_stall, "input taken while result is blocked")
    `AICS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind angle_sum_incircle_test aics_checker u_aics_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
);

/* dv/angle_sum_incircle_checker.sv */
// Checker for the in-circle test block: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module angle_sum_incircle_checker
    import aics_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  in_item_t            in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  out_item_t           out_data,
    input  logic                cfg_we,
    input  logic [TOL_BITS-1:0] cfg_data,
    output int                  fail_count,
    output int                  pending,
    output int                  results_seen,
    output int                  degenerate_seen
);

    localparam longint PI30 = 64'sd3373259426;

    out_item_t       expected_q[$];
    logic [TOL_BITS-1:0] tolerance;

    // Direction of a nonzero vector in Q30, by normalized CORDIC vectoring.
    function automatic longint direction(longint x, longint y);
        longint z;
        longint xs;
        longint ys;
        longint m;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = PI30;
        end
        m = (x > (y < 0 ? -y : y)) ? x : (y < 0 ? -y : y);
        while (m < (64'sd1 <<< 59))
        begin
            m = m * 2;
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_Q30[i]);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_Q30[i]);
            end
        end
        return z;
    endfunction

    // Unsigned angle between two vectors, folded into [0, pi].
    function automatic longint angle_between(longint ux, longint uy, longint vx, longint vy);
        longint d;
        d = direction(ux, uy) - direction(vx, vy);
        if (d < 0)
            d = -d;
        if (d > PI30)
            d = 2 * PI30 - d;
        return d;
    endfunction

    function automatic longint round_angle(longint q30);
        return (q30 + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
    endfunction

    function automatic out_item_t classify_points(in_item_t p, logic [TOL_BITS-1:0] tol);
        out_item_t r;
        longint bax;
        longint bay;
        longint bcx;
        longint bcy;
        longint dax;
        longint day;
        longint dcx;
        longint dcy;
        longint sum;
        longint diff;
        bax = longint'(p.point_a_x) - longint'(p.point_b_x);
        bay = longint'(p.point_a_y) - longint'(p.point_b_y);
        bcx = longint'(p.point_c_x) - longint'(p.point_b_x);
        bcy = longint'(p.point_c_y) - longint'(p.point_b_y);
        dax = longint'(p.point_a_x) - longint'(p.point_d_x);
        day = longint'(p.point_a_y) - longint'(p.point_d_y);
        dcx = longint'(p.point_c_x) - longint'(p.point_d_x);
        dcy = longint'(p.point_c_y) - longint'(p.point_d_y);
        r = '0;
        if ((bax == 0 && bay == 0) || (bcx == 0 && bcy == 0) ||
            (dax == 0 && day == 0) || (dcx == 0 && dcy == 0))
        begin
            r.degenerate = 1'b1;
            return r;
        end
        sum = round_angle(angle_between(bax, bay, bcx, bcy) +
                          angle_between(dax, day, dcx, dcy));
        diff = sum - round_angle(PI30);
        if ((diff < 0 ? -diff : diff) <= longint'(tol))
            r.position = POS_ON;
        else if (diff > 0)
            r.position = POS_INSIDE;
        else
            r.position = POS_OUTSIDE;
        r.angle_sum = sum[SUM_BITS-1:0];
        return r;
    endfunction

    assign pending = expected_q.size();

    // Track the register, predict each input transfer, compare each output transfer.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        int        errs;
        if (!rst_n)
        begin
            tolerance <= '0;
            fail_count <= 0;
            results_seen <= 0;
            degenerate_seen <= 0;
            expected_q.delete();
        end
        else
        begin
            errs = 0;
            if (cfg_we)
                tolerance <= cfg_data;
            if (in_valid && !in_stall)
                expected_q.push_back(classify_points(in_data, tolerance));
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (out_data.degenerate)
                    degenerate_seen <= degenerate_seen + 1;
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with no expectation waiting");
                    errs = errs + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.position !== out_data.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               want.position, out_data.position);
                        errs = errs + 1;
                    end
                    if (want.angle_sum !== out_data.angle_sum)
                    begin
                        $error("angle_sum: expected %0d, actual %0d",
                               want.angle_sum, out_data.angle_sum);
                        errs = errs + 1;
                    end
                    if (want.degenerate !== out_data.degenerate)
                    begin
                        $error("degenerate: expected %0d, actual %0d",
                               want.degenerate, out_data.degenerate);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

/* dv/angle_sum_incircle_test_test.sv */
// Top of the in-circle test bench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module angle_sum_incircle_test_test;
    import aics_pkg::*;

    localparam int LATENCY   = 36;
    localparam int IDLE_MAX  = 20000;
    localparam int HOLD_LONG = 200;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    in_item_t            in_data;
    logic                out_valid;
    logic                out_stall;
    out_item_t           out_data;
    logic                cfg_we;
    logic [TOL_BITS-1:0] cfg_data;
    int                  fail_count;
    int                  pending;
    int                  results_seen;
    int                  degenerate_seen;
    int                  idle_cycles;
    int                  stall_mode;
    bit                  hold_off;
    int                  items_sent;

    angle_sum_incircle_test u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    angle_sum_incircle_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen),
        .degenerate_seen(degenerate_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver stall pattern: mode changes per phase, plus a long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_LONG) @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Watchdog on cycles with no transfer at all.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one item and wait for its transfer.
    task automatic send_points(in_item_t p);
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        in_data  <= in_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
        @(posedge clk);
    endtask

    task automatic drain_and_write(logic [TOL_BITS-1:0] tol);
        drop_valid();
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= tol;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [15:0] near(logic [15:0] base, int spread);
        return base + 16'($urandom_range(0, 2 * spread) - spread);
    endfunction

    // Random point set; kind picks cocircular, near-degenerate or raw noise.
    function automatic in_item_t random_points();
        in_item_t p;
        int kind;
        int r;
        kind = $urandom_range(0, 9);
        p = in_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
        if (kind < 4)
        begin
            // Square-ish quadrilateral with jitter: sums land near pi.
            r = $urandom_range(1, 12000);
            p.point_a_x = near(16'(r), 3);
            p.point_a_y = near(16'h0, 3);
            p.point_b_x = near(16'h0, 3);
            p.point_b_y = near(16'(r), 3);
            p.point_c_x = near(16'(-r), 3);
            p.point_c_y = near(16'h0, 3);
            p.point_d_x = near(16'h0, 3);
            p.point_d_y = near(16'(-r), 3 + $urandom_range(0, 400));
        end
        else if (kind < 6)
        begin
            // Small coordinates so that coincident points occur often.
            p.point_a_x = 16'($urandom_range(0, 2));
            p.point_a_y = 16'($urandom_range(0, 2));
            p.point_b_x = 16'($urandom_range(0, 2));
            p.point_b_y = 16'($urandom_range(0, 2));
            p.point_c_x = 16'($urandom_range(0, 2));
            p.point_c_y = 16'($urandom_range(0, 2));
            p.point_d_x = 16'($urandom_range(0, 2));
            p.point_d_y = 16'($urandom_range(0, 2));
        end
        return p;
    endfunction

    initial
    begin
        in_item_t p;
        int burst;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        idle_cycles = 0;
        stall_mode = 0;
        hold_off   = 1'b0;
        items_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, cocircular square, inside, outside, degenerate.
        send_points('{16'sd256, 16'sd0, 16'sd0, 16'sd256, -16'sd256, 16'sd0, 16'sd0, -16'sd256});
        send_points('{16'sd256, 16'sd0, 16'sd0, 16'sd256, -16'sd256, 16'sd0, 16'sd0, -16'sd10});
        send_points('{16'sd256, 16'sd0, 16'sd0, 16'sd256, -16'sd256, 16'sd0, 16'sd0, -16'sd9000});
        send_points('{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd1, 16'sd2, 16'sd3, 16'sd4});
        send_points('{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd4});
        send_points('{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd2, 16'sd3, 16'sd1, 16'sd1});
        send_points('{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd2, 16'sd3, 16'sd2, 16'sd3});
        send_points('{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                      16'h8000, 16'h7fff});
        send_points('{16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                      16'h7fff, 16'h7fff});
        send_points('{16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'h0001, 16'h0000,
                      16'h0000, 16'h0001});
        send_points('{16'sd100, 16'sd0, 16'sd0, 16'sd0, -16'sd100, 16'sd0, 16'sd0, 16'sd50});
        send_points('{16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd50, 16'sd0, 16'sd0, 16'sd50});
        send_points('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                      16'hffff, 16'hffff});

        // Random phases at several tolerances, extremes included.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: drain_and_write(TOL_BITS'(8191));
                1: drain_and_write(TOL_BITS'($urandom_range(1, 64)));
                2: drain_and_write(TOL_BITS'($urandom_range(0, 8191)));
                3: drain_and_write(TOL_BITS'(5461));
                default: drain_and_write('0);
            endcase
            stall_mode = phase % 4;
            if (phase == 2)
                hold_off = 1'b1;
            for (int n = 0; n < 80; )
            begin
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst; k++, n++)
                    send_points(random_points());
                if ($urandom_range(0, 2) != 0)
                begin
                    drop_valid();
                    repeat ($urandom_range(0, 6)) @(posedge clk);
                end
            end
        end

        // Pause until every expected result has come, then finish.
        drop_valid();
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        $display("Covered %0d point sets, %0d results, %0d degenerate, five tolerance phases.",
                 items_sent, results_seen, degenerate_seen);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/aics_pkg.sv
rtl/aics_cordic.sv
rtl/angle_sum_incircle_test.sv
rtl/aics_checker.sv
dv/angle_sum_incircle_checker.sv
dv/angle_sum_incircle_test_test.sv
